[design/dws_pkg.sv]
`default_nettype none
package dws_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 4;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_SEARCH     = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SEARCH
    } t_state;

    // Ring slot at a given offset from the front; offset stays below DEPTH.
    function automatic t_addr slot_at(t_addr front, t_addr offset);
        logic [ADDR_W:0] sum;
        begin
            sum = {1'b0, front} + {1'b0, offset};
            if (sum >= (ADDR_W+1)'(DEPTH)) begin
                sum = sum - (ADDR_W+1)'(DEPTH);
            end
            slot_at = sum[ADDR_W-1:0];
        end
    endfunction

    function automatic t_addr slot_before(t_addr front);
        begin
            if (front == '0) begin
                slot_before = t_addr'(DEPTH - 1);
            end else begin
                slot_before = front - t_addr'(1);
            end
        end
    endfunction

endpackage
`default_nettype wire

[design/deque_with_search_top.sv]
// Channel   Ports                                  Handshake
// request   i_req_type, i_value                    i_start high while o_busy low
// result    o_status, o_data, o_position           o_done high for one cycle
//
// Inserts give their result in the next cycle; a new request can
// follow right away. A remove reads the front slot through the registered
// RAM read, then gives its result from the pop state. A search reads one
// stored entry per cycle from the single RAM read port, up to DEPTH entries.
// Reset (synchronous, active low) empties the ring; RAM contents are kept.
// The receiver cannot stall; each result is shown once.
`default_nettype none
module deque_with_search_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [1:0]         i_req_type,
    input  wire logic signed [31:0] i_value,
    output logic                    o_busy,
    output logic                    o_done,
    output logic [1:0]              o_status,
    output logic signed [31:0]      o_data,
    output logic [3:0]              o_position
);

    logic                       wr_en;
    dws_pkg::t_addr             wr_addr;
    logic [dws_pkg::DATA_W-1:0] wr_data;
    dws_pkg::t_addr             rd_addr;
    logic [dws_pkg::DATA_W-1:0] rd_data;

    dws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .i_value    (i_value),
        .o_busy     (o_busy),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_data     (o_data),
        .o_position (o_position),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    dws_ram #(
        .WIDTH  (dws_pkg::DATA_W),
        .DEPTH  (dws_pkg::DEPTH),
        .ADDR_W (dws_pkg::ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
`default_nettype wire

[design/dws_ram.sv]
`default_nettype none
module dws_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[i_rd_addr];
    end

endmodule
`default_nettype wire

[design/dws_ctrl.sv]
`default_nettype none
module dws_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [1:0]                  i_req_type,
    input  wire logic signed [31:0]          i_value,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic signed [31:0]               o_data,
    output logic [3:0]                       o_position,
    output logic                             o_wr_en,
    output dws_pkg::t_addr                   o_wr_addr,
    output logic [dws_pkg::DATA_W-1:0]       o_wr_data,
    output dws_pkg::t_addr                   o_rd_addr,
    input  wire logic [dws_pkg::DATA_W-1:0]  i_rd_data
);

    dws_pkg::t_state r_state, n_state;
    dws_pkg::t_addr  r_front, n_front;
    dws_pkg::t_cnt   r_count, n_count;
    dws_pkg::t_addr  r_off, n_off;
    logic [dws_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [dws_pkg::DATA_W-1:0] r_key, n_key;
    logic                       r_done, n_done;
    dws_pkg::t_status           r_status, n_status;
    logic [dws_pkg::DATA_W-1:0] r_data, n_data;
    logic [dws_pkg::POS_W-1:0]  r_position, n_position;

    logic accept;
    logic is_full;
    logic is_empty;
    logic hit;
    logic last;
    dws_pkg::t_req req;

    assign accept   = i_start && (r_state == dws_pkg::S_IDLE);
    assign req      = dws_pkg::t_req'(i_req_type);
    assign is_full  = (r_count == dws_pkg::t_cnt'(dws_pkg::DEPTH));
    assign is_empty = (r_count == '0);
    assign hit      = (i_rd_data == r_key);
    assign last     = ((dws_pkg::t_cnt'(r_off) + dws_pkg::t_cnt'(1)) == r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dws_pkg::S_IDLE: begin
                if (accept) begin
                    if (req == dws_pkg::REQ_POP_FRONT && !is_empty) begin
                        n_state = dws_pkg::S_POP;
                    end else if (req == dws_pkg::REQ_SEARCH && !is_empty) begin
                        n_state = dws_pkg::S_SEARCH;
                    end
                end
            end
            dws_pkg::S_POP: begin
                n_state = dws_pkg::S_IDLE;
            end
            dws_pkg::S_SEARCH: begin
                if (hit || last) begin
                    n_state = dws_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dws_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_front    = r_front;
        n_count    = r_count;
        n_off      = r_off;
        n_pos      = r_pos;
        n_key      = r_key;
        n_done     = 1'b0;
        n_status   = r_status;
        n_data     = r_data;
        n_position = r_position;
        o_wr_en    = 1'b0;
        o_wr_addr  = dws_pkg::slot_before(r_front);
        o_wr_data  = i_value;
        o_rd_addr  = r_front;
        unique case (r_state)
            dws_pkg::S_IDLE: begin
                if (accept) begin
                    n_status   = dws_pkg::ST_OK;
                    n_data     = '0;
                    n_position = '0;
                    n_key      = i_value;
                    n_off      = '0;
                    n_pos      = '0;
                    unique case (req)
                        dws_pkg::REQ_PUSH_FRONT: begin
                            n_done = 1'b1;
                            if (is_full) begin
                                n_status = dws_pkg::ST_FULL;
                            end else begin
                                o_wr_en = 1'b1;
                                n_front = dws_pkg::slot_before(r_front);
                                n_count = r_count + dws_pkg::t_cnt'(1);
                            end
                        end
                        dws_pkg::REQ_PUSH_BACK: begin
                            n_done    = 1'b1;
                            o_wr_addr = dws_pkg::slot_at(r_front,
                                                         r_count[dws_pkg::ADDR_W-1:0]);
                            if (is_full) begin
                                n_status = dws_pkg::ST_FULL;
                            end else begin
                                o_wr_en = 1'b1;
                                n_count = r_count + dws_pkg::t_cnt'(1);
                            end
                        end
                        dws_pkg::REQ_POP_FRONT: begin
                            if (is_empty) begin
                                n_done   = 1'b1;
                                n_status = dws_pkg::ST_EMPTY;
                                n_data   = '1;
                            end
                        end
                        dws_pkg::REQ_SEARCH: begin
                            if (is_empty) begin
                                n_done   = 1'b1;
                                n_status = dws_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_done = 1'b0;
                        end
                    endcase
                end
            end
            dws_pkg::S_POP: begin
                n_done   = 1'b1;
                n_data   = i_rd_data;
                n_front  = dws_pkg::slot_at(r_front, dws_pkg::t_addr'(1));
                n_count  = r_count - dws_pkg::t_cnt'(1);
            end
            dws_pkg::S_SEARCH: begin
                // Fetch the next slot while comparing the current one.
                o_rd_addr = dws_pkg::slot_at(r_front, r_off + dws_pkg::t_addr'(1));
                if (hit) begin
                    n_done     = 1'b1;
                    n_status   = dws_pkg::ST_OK;
                    n_position = r_pos;
                end else if (last) begin
                    n_done   = 1'b1;
                    n_status = dws_pkg::ST_NOT_FOUND;
                end else begin
                    n_off = r_off + dws_pkg::t_addr'(1);
                    n_pos = r_pos + 4'd1;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dws_pkg::S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_off      <= n_off;
        r_pos      <= n_pos;
        r_key      <= n_key;
        r_status   <= n_status;
        r_data     <= n_data;
        r_position <= n_position;
    end

    assign o_busy     = (r_state != dws_pkg::S_IDLE);
    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_data     = r_data;
    assign o_position = r_position;

endmodule
`default_nettype wire

[verif/tb_top.sv]
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_REQUESTS = 1420;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct {
        dws_pkg::t_req      kind;
        logic signed [31:0] value;
        int                 gap;
    } t_deque_request;

    typedef struct packed {
        dws_pkg::t_status   status;
        logic signed [31:0] data;
        logic [3:0]         position;
    } t_deque_result;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} t_phase;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_start    = 1'b0;
    logic [1:0]         i_req_type = '0;
    logic signed [31:0] i_value    = '0;
    logic               o_busy;
    logic               o_done;
    logic [1:0]         o_status;
    logic signed [31:0] o_data;
    logic [3:0]         o_position;

    deque_with_search_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .i_value    (i_value),
        .o_busy     (o_busy),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_data     (o_data),
        .o_position (o_position)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Requests waiting to be driven, and results still owed by the block
    t_deque_request     stim_requests[$];
    t_deque_result      pending_results[$];

    // Shadow deque
    logic signed [31:0] ring_vals[dws_pkg::DEPTH];
    int                 ring_head    = 0;
    int                 ring_held    = 0;

    int                 accepted_cnt = 0;
    int                 result_cnt   = 0;
    int                 mismatch_cnt = 0;
    int                 full_refusals = 0;
    int                 empty_removes = 0;
    int                 search_hits  = 0;
    int                 deepest_hit  = 0;
    int                 quiet_cycles = 0;

    // Values of recent insert requests, used as search keys
    logic signed [31:0] recent[16];
    int                 recent_wr    = 0;

    bit                 taken        = 1'b0;
    bit                 have_req     = 1'b0;
    bit                 quiet;
    int                 gap_left     = 0;
    t_deque_request     cur_req;
    t_deque_result      want;

    function automatic t_deque_result deque_apply(dws_pkg::t_req kind,
                                                  logic signed [31:0] val);
        t_deque_result res;
        int            i;
        begin
            res.status   = dws_pkg::ST_OK;
            res.data     = '0;
            res.position = '0;
            case (kind)
                dws_pkg::REQ_PUSH_FRONT, dws_pkg::REQ_PUSH_BACK: begin
                    if (ring_held == dws_pkg::DEPTH) begin
                        res.status = dws_pkg::ST_FULL;
                        full_refusals++;
                    end else if (kind == dws_pkg::REQ_PUSH_FRONT) begin
                        ring_head = (ring_head + dws_pkg::DEPTH - 1) % dws_pkg::DEPTH;
                        ring_vals[ring_head] = val;
                        ring_held++;
                    end else begin
                        ring_vals[(ring_head + ring_held) % dws_pkg::DEPTH] = val;
                        ring_held++;
                    end
                end
                dws_pkg::REQ_POP_FRONT: begin
                    if (ring_held == 0) begin
                        res.status = dws_pkg::ST_EMPTY;
                        res.data   = -32'sd1;
                        empty_removes++;
                    end else begin
                        res.data  = ring_vals[ring_head];
                        ring_head = (ring_head + 1) % dws_pkg::DEPTH;
                        ring_held--;
                    end
                end
                default: begin
                    res.status = dws_pkg::ST_NOT_FOUND;
                    for (i = 0; i < ring_held; i++) begin
                        if (res.status == dws_pkg::ST_NOT_FOUND
                            && ring_vals[(ring_head + i) % dws_pkg::DEPTH] == val) begin
                            res.status   = dws_pkg::ST_OK;
                            res.position = 4'(i);
                        end
                    end
                    if (res.status == dws_pkg::ST_OK) begin
                        search_hits++;
                        if (int'(res.position) > deepest_hit) begin
                            deepest_hit = int'(res.position);
                        end
                    end
                end
            endcase
            deque_apply = res;
        end
    endfunction

    function automatic logic signed [31:0] pick_value();
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: pick_value = 32'($urandom);
                5, 6, 7:       pick_value = 32'($urandom_range(0, 7));
                8: begin
                    case ($urandom_range(0, 3))
                        0:       pick_value = 32'h8000_0000;
                        1:       pick_value = 32'h7fff_ffff;
                        2:       pick_value = 32'hffff_ffff;
                        default: pick_value = 32'h0;
                    endcase
                end
                default:       pick_value = -32'($urandom_range(1, 8));
            endcase
        end
    endfunction

    function automatic void add_request(dws_pkg::t_req kind, logic signed [31:0] val,
                                        int gap);
        t_deque_request r;
        begin
            r.kind  = kind;
            r.value = val;
            r.gap   = gap;
            stim_requests.push_back(r);
            if (kind == dws_pkg::REQ_PUSH_FRONT || kind == dws_pkg::REQ_PUSH_BACK) begin
                recent[recent_wr] = val;
                recent_wr = (recent_wr + 1) % 16;
            end
        end
    endfunction

    // Driver: present one request at a time, hold it until taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (taken) begin
                have_req = 1'b0;
                taken    = 1'b0;
            end
            if (!have_req && stim_requests.size() != 0) begin
                cur_req  = stim_requests.pop_front();
                have_req = 1'b1;
                gap_left = cur_req.gap;
            end
            if (have_req && gap_left == 0) begin
                i_start    <= 1'b1;
                i_req_type <= cur_req.kind;
                i_value    <= cur_req.value;
            end else begin
                if (have_req) begin
                    gap_left--;
                end
                // scramble the payload while idle; the block must ignore it
                i_start    <= 1'b0;
                i_req_type <= 2'($urandom_range(0, 3));
                i_value    <= 32'($urandom);
            end
        end
    end

    // Monitor: check results, then predict the request taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet = 1'b1;
            if (o_done === 1'b1) begin
                quiet = 1'b0;
                result_cnt++;
                if (pending_results.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result: expected none, got status %0d",
                             $realtime, o_status, " data %0d position %0d",
                             o_data, o_position);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status || o_data !== want.data
                        || o_position !== want.position) begin
                        mismatch_cnt++;
                        $display("%0t: result mismatch: expected status %s data %0d",
                                 $realtime, want.status.name(), want.data,
                                 " position %0d, got status %0d data %0d position %0d",
                                 want.position, o_status, o_data, o_position);
                    end
                end
            end
            if (i_start && !o_busy) begin
                quiet = 1'b0;
                pending_results.push_back(deque_apply(dws_pkg::t_req'(i_req_type),
                                                      i_value));
                taken = 1'b1;
                accepted_cnt++;
            end
            quiet_cycles = quiet ? quiet_cycles + 1 : 0;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog: no request or result for %0d cycles",
                         $realtime, quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        t_phase             phase;
        int                 phase_len;
        int                 roll;
        int                 push_pct;
        int                 pop_pct;
        int                 burst_left;
        int                 gap;
        dws_pkg::t_req      kind;
        logic signed [31:0] val;

        foreach (recent[k]) recent[k] = '0;
        burst_left = 0;

        // Directed: empty cases, extremes, duplicates, first match from the front
        add_request(dws_pkg::REQ_POP_FRONT,  32'h7fff_ffff, 0);
        add_request(dws_pkg::REQ_SEARCH,     32'h0,         0);
        add_request(dws_pkg::REQ_PUSH_FRONT, 32'h8000_0000, 0);
        add_request(dws_pkg::REQ_PUSH_BACK,  32'h7fff_ffff, 0);
        add_request(dws_pkg::REQ_PUSH_FRONT, 32'hffff_ffff, 2);
        add_request(dws_pkg::REQ_PUSH_BACK,  32'h0,         0);
        add_request(dws_pkg::REQ_PUSH_BACK,  32'hffff_ffff, 0);
        add_request(dws_pkg::REQ_SEARCH,     32'hffff_ffff, 0);
        add_request(dws_pkg::REQ_SEARCH,     32'h0,         1);
        add_request(dws_pkg::REQ_SEARCH,     32'h7fff_ffff, 0);
        add_request(dws_pkg::REQ_SEARCH,     32'd12345,     0);
        add_request(dws_pkg::REQ_POP_FRONT,  32'h5555_5555, 0);
        add_request(dws_pkg::REQ_SEARCH,     32'hffff_ffff, 0);
        add_request(dws_pkg::REQ_SEARCH,     32'h8000_0000, 3);
        repeat (4) add_request(dws_pkg::REQ_POP_FRONT, 32'haaaa_aaaa, 0);
        add_request(dws_pkg::REQ_POP_FRONT,  32'h0,         0);
        add_request(dws_pkg::REQ_SEARCH,     32'hffff_ffff, 0);

        // Random: phases that fill, drain or mix, sent in bursts
        while (stim_requests.size() < TOTAL_REQUESTS) begin
            phase     = t_phase'($urandom_range(0, 2));
            phase_len = $urandom_range(20, 80);
            case (phase)
                PH_FILL:  begin push_pct = 75; pop_pct = 10; end
                PH_DRAIN: begin push_pct = 10; pop_pct = 70; end
                default:  begin push_pct = 40; pop_pct = 30; end
            endcase
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct) begin
                    kind = $urandom_range(0, 1) ? dws_pkg::REQ_PUSH_BACK
                                                : dws_pkg::REQ_PUSH_FRONT;
                end else if (roll < push_pct + pop_pct) begin
                    kind = dws_pkg::REQ_POP_FRONT;
                end else begin
                    kind = dws_pkg::REQ_SEARCH;
                end
                if (kind == dws_pkg::REQ_SEARCH && $urandom_range(0, 9) < 6) begin
                    val = recent[$urandom_range(0, 15)];
                end else begin
                    val = pick_value();
                end
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 12);
                    gap = $urandom_range(1, 8);
                end else begin
                    gap = 0;
                end
                burst_left--;
                add_request(kind, val, gap);
            end
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_requests.size() != 0 || have_req) begin
            @(posedge i_clk);
        end
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        // let a stray late result show up
        repeat (dws_pkg::DEPTH + 4) @(posedge i_clk);

        $display("covered %0d requests, %0d results: %0d inserts refused on full,",
                 accepted_cnt, result_cnt, full_refusals);
        $display("%0d removes on empty, %0d search hits, deepest hit at %0d, %0d mismatches",
                 empty_removes, search_hits, deepest_hit, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
design/dws_pkg.sv
design/dws_ram.sv
design/dws_ctrl.sv
design/deque_with_search_top.sv
verif/tb_top.sv
